// ===== hw/rtl/abscj_pkg.sv =====
// ----------------------------------------------------------------------------
// abscj_pkg
// Shared types and codes for the A/B slot commit journal: event modes, slot,
// record state and format codes, register indexes and snapshot structures.
// ----------------------------------------------------------------------------
package abscj_pkg;

   // Default generation width and configuration data width
   localparam int GENERATION_BITS_DEFAULT = 32;
   localparam int CSR_DATA_BITS           = 32;
   localparam int CSR_INDEX_BITS          = 1;

   // Event modes (codes six and seven are unused)
   typedef enum logic [2:0] {
      MODE_RESTART  = 3'd0,
      MODE_PREPARE  = 3'd1,
      MODE_VERIFY   = 3'd2,
      MODE_COMMIT   = 3'd3,
      MODE_ROLLBACK = 3'd4,
      MODE_RECOVER  = 3'd5
   } mode_type;

   // Slot codes
   localparam logic [1:0] SLOT_NONE    = 2'd0;
   localparam logic [1:0] SLOT_A       = 2'd1;
   localparam logic [1:0] SLOT_B       = 2'd2;
   localparam logic [1:0] SLOT_INVALID = 2'd3;

   // Record state codes
   localparam logic [1:0] REC_EMPTY     = 2'd0;
   localparam logic [1:0] REC_PREPARED  = 2'd1;
   localparam logic [1:0] REC_COMMITTED = 2'd2;
   localparam logic [1:0] REC_INVALID   = 2'd3;

   // Record format codes
   localparam logic [1:0] FMT_BAD_SCHEMA = 2'd0;
   localparam logic [1:0] FMT_EMPTY      = 2'd1;
   localparam logic [1:0] FMT_VALID      = 2'd2;
   localparam logic [1:0] FMT_MALFORMED  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_SLOT       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_GENERATION = 1'd1;

   // Control fields of one stored slot record
   typedef struct packed {
      logic [1:0] slot;
      logic [1:0] state;
      logic [1:0] format;
   } rec_ctl_type;

   // Status part of a snapshot (generations travel alongside)
   typedef struct packed {
      logic       ok;
      logic [1:0] act_slot;
      logic [1:0] cand_slot;
      logic       prep;
      logic       ver;
      logic       comm;
   } snap_type;

endpackage

// ===== hw/rtl/ab_slot_commit_journal.sv =====
// ----------------------------------------------------------------------------
// ab_slot_commit_journal
// Two-slot (A/B) credential journal with two-phase commit and record recovery.
// ----------------------------------------------------------------------------
// Path: a taken request goes from the input register through the event logic to
//   the result register. Throughput: one transaction per cycle while rsp_stall
//   is low; input register, event logic and result register act in one pass.
// Reset: synchronous, active high; clears journal state, the configuration
//   registers and both pipeline valids. No clearing pass.
// ----------------------------------------------------------------------------
module ab_slot_commit_journal #(
   parameter int GENERATION_BITS = abscj_pkg::GENERATION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration port
   input  logic                                 csr_write,
   input  logic [abscj_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [abscj_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_mode,
   input  logic [GENERATION_BITS-1:0]           req_generation,
   input  logic                                 req_digest_ok,
   input  logic [1:0]                           req_a_slot,
   input  logic [1:0]                           req_a_state,
   input  logic [1:0]                           req_a_format,
   input  logic [GENERATION_BITS-1:0]           req_a_generation,
   input  logic [1:0]                           req_b_slot,
   input  logic [1:0]                           req_b_state,
   input  logic [1:0]                           req_b_format,
   input  logic [GENERATION_BITS-1:0]           req_b_generation,
   input  logic [1:0]                           req_mark_slot,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic [1:0]                           rsp_active_slot_out,
   output logic [GENERATION_BITS-1:0]           rsp_active_generation_out,
   output logic [1:0]                           rsp_candidate_slot_out,
   output logic [GENERATION_BITS-1:0]           rsp_candidate_generation_out,
   output logic                                 rsp_prepared_out,
   output logic                                 rsp_verified_out,
   output logic                                 rsp_committed_out
);
   import abscj_pkg::*;

   // configuration registers
   logic [1:0]                 init_slot_ff;
   logic [CSR_DATA_BITS-1:0]   init_gen_ff;

   // input register
   logic                       in_valid_ff;
   logic                       take;
   logic [2:0]                 mode_ff;
   logic [GENERATION_BITS-1:0] gen_ff;
   logic                       digest_ok_ff;
   rec_ctl_type                a_ctl_ff;
   logic [GENERATION_BITS-1:0] a_gen_ff;
   rec_ctl_type                b_ctl_ff;
   logic [GENERATION_BITS-1:0] b_gen_ff;
   logic [1:0]                 mark_slot_ff;

   // result register
   logic                       out_valid_ff;
   snap_type                   out_snap_ff;
   logic [GENERATION_BITS-1:0] out_act_gen_ff;
   logic [GENERATION_BITS-1:0] out_cand_gen_ff;

   logic                       advance;
   logic                       fire;
   snap_type                   rcv;
   logic [GENERATION_BITS-1:0] rcv_act_gen;
   logic [GENERATION_BITS-1:0] rcv_cand_gen;
   snap_type                   snap;
   logic [GENERATION_BITS-1:0] snap_act_gen;
   logic [GENERATION_BITS-1:0] snap_cand_gen;

   // Pipeline flow control
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_slot_ff <= SLOT_NONE;
         init_gen_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INITIAL_SLOT: begin
               init_slot_ff <= csr_wdata[1:0];
            end
            CSR_INITIAL_GENERATION: begin
               init_gen_ff <= csr_wdata;
            end
            default: begin
               init_slot_ff <= init_slot_ff;
            end
         endcase
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Input payload register
   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff         <= req_mode;
         gen_ff          <= req_generation;
         digest_ok_ff    <= req_digest_ok;
         a_ctl_ff.slot   <= req_a_slot;
         a_ctl_ff.state  <= req_a_state;
         a_ctl_ff.format <= req_a_format;
         a_gen_ff        <= req_a_generation;
         b_ctl_ff.slot   <= req_b_slot;
         b_ctl_ff.state  <= req_b_state;
         b_ctl_ff.format <= req_b_format;
         b_gen_ff        <= req_b_generation;
         mark_slot_ff    <= req_mark_slot;
      end
   end

   abscj_recover #(
      .GENERATION_BITS(GENERATION_BITS)
   ) u_recover (
      .a_ctl        (a_ctl_ff),
      .a_gen        (a_gen_ff),
      .b_ctl        (b_ctl_ff),
      .b_gen        (b_gen_ff),
      .mark_slot    (mark_slot_ff),
      .marker_gen   (gen_ff),
      .rcv          (rcv),
      .rcv_act_gen  (rcv_act_gen),
      .rcv_cand_gen (rcv_cand_gen)
   );

   abscj_state #(
      .GENERATION_BITS(GENERATION_BITS)
   ) u_state (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .mode          (mode_ff),
      .gen           (gen_ff),
      .digest_ok     (digest_ok_ff),
      .init_slot     (init_slot_ff),
      .init_gen      (GENERATION_BITS'(init_gen_ff)),
      .rcv           (rcv),
      .rcv_act_gen   (rcv_act_gen),
      .rcv_cand_gen  (rcv_cand_gen),
      .snap          (snap),
      .snap_act_gen  (snap_act_gen),
      .snap_cand_gen (snap_cand_gen)
   );

   // Result payload register
   always_ff @(posedge clock) begin
      if (fire) begin
         out_snap_ff     <= snap;
         out_act_gen_ff  <= snap_act_gen;
         out_cand_gen_ff <= snap_cand_gen;
      end
   end

   assign rsp_valid                    = out_valid_ff;
   assign rsp_ok                       = out_snap_ff.ok;
   assign rsp_active_slot_out          = out_snap_ff.act_slot;
   assign rsp_active_generation_out    = out_act_gen_ff;
   assign rsp_candidate_slot_out       = out_snap_ff.cand_slot;
   assign rsp_candidate_generation_out = out_cand_gen_ff;
   assign rsp_prepared_out             = out_snap_ff.prep;
   assign rsp_verified_out             = out_snap_ff.ver;
   assign rsp_committed_out            = out_snap_ff.comm;

endmodule

// ===== hw/rtl/abscj_recover.sv =====
// ----------------------------------------------------------------------------
// abscj_recover
// Checks two slot records against a commit marker and derives the snapshot
// they describe. Purely combinational; a failed check gives an all-zero result.
// ----------------------------------------------------------------------------
module abscj_recover #(
   parameter int GENERATION_BITS = abscj_pkg::GENERATION_BITS_DEFAULT
) (
   input  abscj_pkg::rec_ctl_type        a_ctl,
   input  logic [GENERATION_BITS-1:0]    a_gen,
   input  abscj_pkg::rec_ctl_type        b_ctl,
   input  logic [GENERATION_BITS-1:0]    b_gen,
   input  logic [1:0]                    mark_slot,
   input  logic [GENERATION_BITS-1:0]    marker_gen,
   output abscj_pkg::snap_type           rcv,
   output logic [GENERATION_BITS-1:0]    rcv_act_gen,
   output logic [GENERATION_BITS-1:0]    rcv_cand_gen
);
   import abscj_pkg::*;

   localparam logic [GENERATION_BITS-1:0] GEN_ZERO = '0;

   logic                       fit_a;
   logic                       fit_b;
   logic                       both_fit;
   logic                       pa;
   logic                       pb;
   rec_ctl_type                m_ctl;
   rec_ctl_type                o_ctl;
   logic [GENERATION_BITS-1:0] m_gen;
   logic [GENERATION_BITS-1:0] o_gen;
   logic                       marked_good;

   // Record is consistent with its physical slot
   function automatic logic record_fits(rec_ctl_type r, logic [GENERATION_BITS-1:0] g,
                                        logic [1:0] phys);
      logic res;
      res = 1'b0;
      if (r.format != FMT_BAD_SCHEMA) begin
         case (r.state)
            REC_EMPTY: begin
               res = ((r.slot == SLOT_NONE) || (r.slot == phys)) && (g == GEN_ZERO) &&
                     (r.format == FMT_EMPTY);
            end
            REC_PREPARED, REC_COMMITTED: begin
               res = (r.slot == phys) && (g != GEN_ZERO) && (r.format == FMT_VALID);
            end
            default: begin
               res = 1'b0;
            end
         endcase
      end
      return res;
   endfunction

   assign fit_a    = record_fits(a_ctl, a_gen, SLOT_A);
   assign fit_b    = record_fits(b_ctl, b_gen, SLOT_B);
   assign both_fit = fit_a && fit_b;
   assign pa       = (a_ctl.state == REC_PREPARED);
   assign pb       = (b_ctl.state == REC_PREPARED);

   // Marked and other record selection
   assign m_ctl = (mark_slot == SLOT_A) ? a_ctl : b_ctl;
   assign m_gen = (mark_slot == SLOT_A) ? a_gen : b_gen;
   assign o_ctl = (mark_slot == SLOT_A) ? b_ctl : a_ctl;
   assign o_gen = (mark_slot == SLOT_A) ? b_gen : a_gen;

   assign marked_good = both_fit && (marker_gen != GEN_ZERO) &&
                        (m_ctl.state == REC_COMMITTED) && (m_ctl.slot == mark_slot) &&
                        (m_gen == marker_gen);

   // Snapshot derivation
   always_comb begin
      rcv          = '0;
      rcv_act_gen  = '0;
      rcv_cand_gen = '0;
      if (mark_slot == SLOT_NONE) begin
         // no marker: no committed record, at most one prepared
         if (both_fit && (marker_gen == GEN_ZERO) && (a_ctl.state != REC_COMMITTED) &&
             (b_ctl.state != REC_COMMITTED) && !(pa && pb)) begin
            rcv.ok = 1'b1;
            if (pa) begin
               rcv.cand_slot = a_ctl.slot;
               rcv_cand_gen  = a_gen;
               rcv.prep      = 1'b1;
            end else if (pb) begin
               rcv.cand_slot = b_ctl.slot;
               rcv_cand_gen  = b_gen;
               rcv.prep      = 1'b1;
            end
         end
      end else if ((mark_slot == SLOT_A) || (mark_slot == SLOT_B)) begin
         if (marked_good) begin
            case (o_ctl.state)
               REC_COMMITTED: begin
                  rcv.ok = (o_gen < marker_gen);
               end
               REC_PREPARED: begin
                  rcv.ok = (o_gen > marker_gen);
                  if (o_gen > marker_gen) begin
                     rcv.cand_slot = o_ctl.slot;
                     rcv_cand_gen  = o_gen;
                     rcv.prep      = 1'b1;
                  end
               end
               REC_EMPTY: begin
                  rcv.ok = 1'b1;
               end
               default: begin
                  rcv.ok = 1'b0;
               end
            endcase
            if (rcv.ok) begin
               rcv.act_slot = mark_slot;
               rcv_act_gen  = marker_gen;
               rcv.comm     = 1'b1;
            end else begin
               rcv.cand_slot = SLOT_NONE;
               rcv_cand_gen  = '0;
               rcv.prep      = 1'b0;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/abscj_state.sv =====
// ----------------------------------------------------------------------------
// abscj_state
// Journal state registers and the event logic for restart, prepare, verify,
// commit and rollback. Produces the snapshot for the transaction in flight.
// ----------------------------------------------------------------------------
module abscj_state #(
   parameter int GENERATION_BITS = abscj_pkg::GENERATION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [2:0]                    mode,
   input  logic [GENERATION_BITS-1:0]    gen,
   input  logic                          digest_ok,
   input  logic [1:0]                    init_slot,
   input  logic [GENERATION_BITS-1:0]    init_gen,
   input  abscj_pkg::snap_type           rcv,
   input  logic [GENERATION_BITS-1:0]    rcv_act_gen,
   input  logic [GENERATION_BITS-1:0]    rcv_cand_gen,
   output abscj_pkg::snap_type           snap,
   output logic [GENERATION_BITS-1:0]    snap_act_gen,
   output logic [GENERATION_BITS-1:0]    snap_cand_gen
);
   import abscj_pkg::*;

   localparam logic [GENERATION_BITS-1:0] GEN_ZERO = '0;

   logic [1:0]                 act_slot_ff,  act_slot_in;
   logic [GENERATION_BITS-1:0] act_gen_ff,   act_gen_in;
   logic [1:0]                 cand_slot_ff, cand_slot_in;
   logic [GENERATION_BITS-1:0] cand_gen_ff,  cand_gen_in;
   logic                       prep_ff,      prep_in;
   logic                       ver_ff,       ver_in;
   logic                       comm_ff,      comm_in;
   logic                       ok;

   // Event decode and next state
   always_comb begin
      act_slot_in  = act_slot_ff;
      act_gen_in   = act_gen_ff;
      cand_slot_in = cand_slot_ff;
      cand_gen_in  = cand_gen_ff;
      prep_in      = prep_ff;
      ver_in       = ver_ff;
      comm_in      = comm_ff;
      ok           = 1'b0;
      case (mode)
         MODE_RESTART: begin
            if (((init_slot == SLOT_NONE) == (init_gen == GEN_ZERO)) &&
                (init_slot != SLOT_INVALID)) begin
               ok           = 1'b1;
               act_slot_in  = init_slot;
               act_gen_in   = init_gen;
               cand_slot_in = SLOT_NONE;
               cand_gen_in  = '0;
               prep_in      = 1'b0;
               ver_in       = 1'b0;
               comm_in      = 1'b0;
            end
         end
         MODE_PREPARE: begin
            // gen <= active generation also rejects a zero generation
            if (!prep_ff && !comm_ff && (gen > act_gen_ff) && digest_ok) begin
               ok           = 1'b1;
               cand_slot_in = (act_slot_ff == SLOT_A) ? SLOT_B : SLOT_A;
               cand_gen_in  = gen;
               prep_in      = 1'b1;
               ver_in       = 1'b0;
               comm_in      = 1'b0;
            end
         end
         MODE_VERIFY: begin
            if (prep_ff && !comm_ff) begin
               ok     = 1'b1;
               ver_in = 1'b1;
            end
         end
         MODE_COMMIT: begin
            // verified stays set after commit until restart
            if (prep_ff && ver_ff && !comm_ff) begin
               ok           = 1'b1;
               act_slot_in  = cand_slot_ff;
               act_gen_in   = cand_gen_ff;
               comm_in      = 1'b1;
               prep_in      = 1'b0;
               cand_slot_in = SLOT_NONE;
               cand_gen_in  = '0;
            end
         end
         MODE_ROLLBACK: begin
            if (prep_ff && !comm_ff) begin
               ok           = 1'b1;
               cand_slot_in = SLOT_NONE;
               cand_gen_in  = '0;
               prep_in      = 1'b0;
               ver_in       = 1'b0;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Snapshot: recover reports its own derivation, others the new state
   always_comb begin
      if (mode == MODE_RECOVER) begin
         snap          = rcv;
         snap_act_gen  = rcv_act_gen;
         snap_cand_gen = rcv_cand_gen;
      end else begin
         snap.ok        = ok;
         snap.act_slot  = act_slot_in;
         snap.cand_slot = cand_slot_in;
         snap.prep      = prep_in;
         snap.ver       = ver_in;
         snap.comm      = comm_in;
         snap_act_gen   = act_gen_in;
         snap_cand_gen  = cand_gen_in;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         act_slot_ff  <= SLOT_NONE;
         act_gen_ff   <= '0;
         cand_slot_ff <= SLOT_NONE;
         cand_gen_ff  <= '0;
         prep_ff      <= 1'b0;
         ver_ff       <= 1'b0;
         comm_ff      <= 1'b0;
      end else if (fire) begin
         act_slot_ff  <= act_slot_in;
         act_gen_ff   <= act_gen_in;
         cand_slot_ff <= cand_slot_in;
         cand_gen_ff  <= cand_gen_in;
         prep_ff      <= prep_in;
         ver_ff       <= ver_in;
         comm_ff      <= comm_in;
      end
   end

endmodule

// ===== hw/rtl/abscj_checker.sv =====
// ----------------------------------------------------------------------------
// abscj_checker
// Port-level checks on the journal: response handshake and snapshot
// consistency. Bound to the top level.
// ----------------------------------------------------------------------------
module abscj_checker #(
   parameter int GENERATION_BITS = abscj_pkg::GENERATION_BITS_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_active_slot_out,
   input logic [GENERATION_BITS-1:0] rsp_active_generation_out,
   input logic [1:0]                 rsp_candidate_slot_out,
   input logic [GENERATION_BITS-1:0] rsp_candidate_generation_out,
   input logic                       rsp_prepared_out
);
   import abscj_pkg::*;

   // stalled response transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a candidate exists exactly when prepared is reported
   a_prep_cand: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prepared_out == (rsp_candidate_slot_out != SLOT_NONE)))
      else $error("prepared flag disagrees with candidate slot");

   // no candidate means zero candidate generation
   a_cand_gen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_candidate_slot_out == SLOT_NONE) |->
         (rsp_candidate_generation_out == '0))
      else $error("candidate generation without candidate slot");

   // active slot is never invalid, and none goes with generation zero
   a_act_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_slot_out != SLOT_INVALID) &&
         ((rsp_active_slot_out == SLOT_NONE) == (rsp_active_generation_out == '0)))
      else $error("active slot and generation inconsistent");

endmodule

bind ab_slot_commit_journal abscj_checker #(
   .GENERATION_BITS(GENERATION_BITS)
) u_abscj_checker (
   .clock                        (clock),
   .reset                        (reset),
   .rsp_valid                    (rsp_valid),
   .rsp_stall                    (rsp_stall),
   .rsp_active_slot_out          (rsp_active_slot_out),
   .rsp_active_generation_out    (rsp_active_generation_out),
   .rsp_candidate_slot_out       (rsp_candidate_slot_out),
   .rsp_candidate_generation_out (rsp_candidate_generation_out),
   .rsp_prepared_out             (rsp_prepared_out)
);
